@@ src/movable_feast_dates_defines.svh @@
// assertion macros shared by the movable feast date block
`ifndef MOVABLE_FEAST_DATES_DEFINES_SVH
`define MOVABLE_FEAST_DATES_DEFINES_SVH

// cause implies effect a fixed number of cycles later
`define MFD_ASSERT_LATER(label, clk, rst_n, cause, effect, lat, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cause) |-> ##(lat) (effect)) else $error(msg);

// effect implies cause a fixed number of cycles earlier
`define MFD_ASSERT_EARLIER(label, clk, rst_n, effect, cause, lat, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (effect) |-> $past((cause), (lat))) else $error(msg);

// condition implies property in the same cycle
`define MFD_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (prop)) else $error(msg);

`endif

@@ src/mfd_pkg.sv @@
// types, constants and the date conversion function of the movable feast date block
`timescale 1ns / 1ps

package mfd_pkg;

    // cycles from an accepted item to its result strobe
    localparam int LATENCY = 8;

    // month starts after march as days since march 1; offsets here stay below 128
    localparam int MONTHS = 4;
    localparam logic [6:0] MONTH_START [0:MONTHS-1] = '{7'd31, 7'd61, 7'd92, 7'd122};

    localparam logic [4:0] FEB_DAYS_COMMON = 5'd28;

    // easter found for one item, handed to the date stage
    typedef struct packed {
        logic       valid;
        logic       leap;
        logic [5:0] off;
    } t_easter_item;

    typedef struct packed {
        logic [3:0] mon;
        logic [4:0] dom;
    } t_date;

    // days since march 1 (negative reaches into february) to month and day
    function automatic t_date date_of(input logic signed [7:0] off, input logic leap);
        t_date             r;
        logic [4:0]        feb;
        logic signed [8:0] dn;
        logic [6:0]        base;
        logic [7:0]        dd;
        r    = '0;
        feb  = FEB_DAYS_COMMON + {4'b0, leap};
        base = '0;
        dn   = '0;
        dd   = '0;
        if (off < 8'sd0) begin
            // february, counted back from its last day
            dn    = $signed({4'b0, feb}) + $signed({off[7], off}) + 9'sd1;
            r.mon = 4'd2;
            r.dom = (dn < 9'sd1) ? 5'd1 : dn[4:0];
        end else begin
            r.mon = 4'd3;
            for (int j = 0; j < MONTHS; j++) begin
                if (off >= $signed({1'b0, MONTH_START[j]})) begin
                    r.mon = 4'(j + 4);
                    base  = MONTH_START[j];
                end
            end
            dd    = off - {1'b0, base} + 8'd1;
            r.dom = dd[4:0];
        end
        return r;
    endfunction

endpackage

@@ src/movable_feast_dates.sv @@
// top level of the movable feast date block
// usage:
//   raise start with a year on i_year; the item is taken at a rising edge with
//   start high and busy low. busy stays low, so a new year may be given in
//   every cycle.
//   each item yields one result: easter, carnival start and end, good friday,
//   ascension and whitsuntide as month and day. the result sits on the o_
//   ports for one cycle with o_strobe high, once the item has passed the
//   easter stages and the registered date stage; results come out
//   in the order the years came in.
//   throughput is one item per cycle; the pipeline is the chain of constant
//   divisions (seven stages) followed by the date conversion stage.
//   the receiver cannot stall; results must be taken when o_strobe is high.
//   a synchronous reset on i_rst_n drops all items in flight; the first
//   item may be given in the cycle after reset is released.
`timescale 1ns / 1ps
`include "movable_feast_dates_defines.svh"

module movable_feast_dates (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_year,
    output logic        o_strobe,
    output logic [2:0]  o_easter_mon,
    output logic [4:0]  o_easter_dom,
    output logic [1:0]  o_carnival_start_mon,
    output logic [4:0]  o_carnival_start_dom,
    output logic [1:0]  o_carnival_end_mon,
    output logic [4:0]  o_carnival_end_dom,
    output logic [2:0]  o_good_friday_mon,
    output logic [4:0]  o_good_friday_dom,
    output logic [2:0]  o_ascension_mon,
    output logic [4:0]  o_ascension_dom,
    output logic [2:0]  o_whitsun_mon,
    output logic [4:0]  o_whitsun_dom
);

    logic                  w_accept;
    mfd_pkg::t_easter_item w_item;

    // the pipeline never holds off an item
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // easter computus stages
    mfd_easter u_easter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_year   (i_year),
        .o_item   (w_item)
    );

    // calendar stage
    mfd_dates u_dates (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_item               (w_item),
        .o_strobe             (o_strobe),
        .o_easter_mon         (o_easter_mon),
        .o_easter_dom         (o_easter_dom),
        .o_carnival_start_mon (o_carnival_start_mon),
        .o_carnival_start_dom (o_carnival_start_dom),
        .o_carnival_end_mon   (o_carnival_end_mon),
        .o_carnival_end_dom   (o_carnival_end_dom),
        .o_good_friday_mon    (o_good_friday_mon),
        .o_good_friday_dom    (o_good_friday_dom),
        .o_ascension_mon      (o_ascension_mon),
        .o_ascension_dom      (o_ascension_dom),
        .o_whitsun_mon        (o_whitsun_mon),
        .o_whitsun_dom        (o_whitsun_dom)
    );

    // every accepted item comes out after the pipeline latency
    `MFD_ASSERT_LATER(a_item_out, i_clk, i_rst_n, w_accept, o_strobe, mfd_pkg::LATENCY, "item lost in pipeline")
    // no result without an item taken that many cycles before
    `MFD_ASSERT_EARLIER(a_no_extra, i_clk, i_rst_n, o_strobe, w_accept, mfd_pkg::LATENCY, "result without item")
    // easter falls in march or april and whitsuntide in may or june
    `MFD_ASSERT_IMPLY(a_month_range, i_clk, i_rst_n, o_strobe, ((o_easter_mon == 3'd3) || (o_easter_mon == 3'd4)) && ((o_whitsun_mon == 3'd5) || (o_whitsun_mon == 3'd6)), "feast month out of range")

endmodule

@@ src/mfd_easter.sv @@
// seven stage pipeline computing easter as days since march 1 plus the leap flag
`timescale 1ns / 1ps

module mfd_easter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [15:0]          i_year,
    output mfd_pkg::t_easter_item o_item
);

    // valid bits, one per stage
    logic [6:0] r_vld;
    logic [6:0] n_vld;

    // stage 1: reciprocal products for year / 100 and year / 19
    logic [15:0] r_y1;
    logic [32:0] r_p100;
    logic [31:0] r_p19;

    // stage 2: a, b, c, f, leap
    logic [4:0]  r_a2;
    logic [9:0]  r_b2;
    logic [6:0]  r_c2;
    logic [4:0]  r_f2;
    logic        r_leap2;

    // stage 3: g and the partial sum for h
    logic [7:0]  r_g3;
    logic [9:0]  r_s3;
    logic [4:0]  r_a3;
    logic [1:0]  r_e3;
    logic [4:0]  r_i3;
    logic [1:0]  r_k3;
    logic        r_leap3;

    // stage 4: sum for h and its reciprocal product
    logic [9:0]  r_x4;
    logic [21:0] r_px4;
    logic [4:0]  r_a4;
    logic [1:0]  r_e4;
    logic [4:0]  r_i4;
    logic [1:0]  r_k4;
    logic        r_leap4;

    // stage 5: h and the sum for l
    logic [4:0]  r_h5;
    logic [6:0]  r_lx5;
    logic [4:0]  r_a5;
    logic        r_leap5;

    // stage 6: l
    logic [4:0]  r_h6;
    logic [2:0]  r_l6;
    logic [4:0]  r_a6;
    logic        r_leap6;

    // stage 7: easter offset
    logic [5:0]  r_off7;
    logic        r_leap7;

    // stage 1 logic
    logic [32:0] n_p100;
    logic [31:0] n_p19;
    // stage 2 logic
    logic [9:0]  w_b;
    logic [11:0] w_q19;
    logic [15:0] w_a16;
    logic [15:0] w_c16;
    logic [10:0] w_b8;
    logic [15:0] w_pf;
    logic        w_leap;
    // stage 3 logic
    logic [9:0]  w_gx;
    logic [19:0] w_pg;
    logic [10:0] w_s;
    // stage 4 logic
    logic [9:0]  w_x;
    // stage 5 logic
    logic [9:0]  w_h10;
    // stage 6 logic
    logic [13:0] w_pl;
    logic [6:0]  w_l7;
    // stage 7 logic
    logic [8:0]  w_mv;
    logic        w_m;
    logic [5:0]  w_off;

    assign n_vld = {r_vld[5:0], i_accept};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // divisions by constants as multiply and shift, then remainders
    always_comb begin
        n_p100 = {17'b0, i_year} * 33'd83887;
        n_p19  = {16'b0, i_year} * 32'd55189;

        w_b    = r_p100[32:23];
        w_q19  = r_p19[31:20];
        w_a16  = r_y1 - {4'b0, w_q19} * 16'd19;
        w_c16  = r_y1 - {6'b0, w_b} * 16'd100;
        w_leap = ((r_y1[1:0] == 2'd0) && (w_c16[6:0] != 7'd0))
              || ((w_c16[6:0] == 7'd0) && (w_b[1:0] == 2'd0));
        w_b8   = {1'b0, w_b} + 11'd8;
        w_pf   = {5'b0, w_b8} * 16'd41;

        w_gx   = r_b2 - {5'b0, r_f2} + 10'd1;
        w_pg   = {10'b0, w_gx} * 20'd683;
        w_s    = {6'b0, r_a2} * 11'd19 + {1'b0, r_b2} - {3'b0, r_b2[9:2]} + 11'd15;

        w_x    = r_s3 - {2'b0, r_g3};

        w_h10  = r_x4 - {4'b0, r_px4[21:16]} * 10'd30;

        w_pl   = {7'b0, r_lx5} * 14'd147;
        w_l7   = r_lx5 - {3'b0, w_pl[13:10]} * 7'd7;

        w_mv   = {4'b0, r_a6} + {4'b0, r_h6} * 9'd11 + {6'b0, r_l6} * 9'd22;
        w_m    = (w_mv >= 9'd451);
        w_off  = {1'b0, r_h6} + {3'b0, r_l6} + 6'd21 - (w_m ? 6'd7 : 6'd0);
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        r_y1    <= i_year;
        r_p100  <= n_p100;
        r_p19   <= n_p19;

        r_a2    <= w_a16[4:0];
        r_b2    <= w_b;
        r_c2    <= w_c16[6:0];
        r_f2    <= w_pf[14:10];
        r_leap2 <= w_leap;

        r_g3    <= w_pg[18:11];
        r_s3    <= w_s[9:0];
        r_a3    <= r_a2;
        r_e3    <= r_b2[1:0];
        r_i3    <= r_c2[6:2];
        r_k3    <= r_c2[1:0];
        r_leap3 <= r_leap2;

        r_x4    <= w_x;
        r_px4   <= {12'b0, w_x} * 22'd2185;
        r_a4    <= r_a3;
        r_e4    <= r_e3;
        r_i4    <= r_i3;
        r_k4    <= r_k3;
        r_leap4 <= r_leap3;

        r_h5    <= w_h10[4:0];
        r_lx5   <= 7'd32 + {4'b0, r_e4, 1'b0} + {1'b0, r_i4, 1'b0}
                 - {2'b0, w_h10[4:0]} - {5'b0, r_k4};
        r_a5    <= r_a4;
        r_leap5 <= r_leap4;

        r_h6    <= r_h5;
        r_l6    <= w_l7[2:0];
        r_a6    <= r_a5;
        r_leap6 <= r_leap5;

        r_off7  <= w_off;
        r_leap7 <= r_leap6;
    end

    assign o_item.valid = r_vld[6];
    assign o_item.leap  = r_leap7;
    assign o_item.off   = r_off7;

endmodule

@@ src/mfd_dates.sv @@
// final stage turning the easter offset into six month and day pairs
`timescale 1ns / 1ps

module mfd_dates (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mfd_pkg::t_easter_item i_item,
    output logic                  o_strobe,
    output logic [2:0]            o_easter_mon,
    output logic [4:0]            o_easter_dom,
    output logic [1:0]            o_carnival_start_mon,
    output logic [4:0]            o_carnival_start_dom,
    output logic [1:0]            o_carnival_end_mon,
    output logic [4:0]            o_carnival_end_dom,
    output logic [2:0]            o_good_friday_mon,
    output logic [4:0]            o_good_friday_dom,
    output logic [2:0]            o_ascension_mon,
    output logic [4:0]            o_ascension_dom,
    output logic [2:0]            o_whitsun_mon,
    output logic [4:0]            o_whitsun_dom
);

    logic signed [7:0] w_off_e;
    mfd_pkg::t_date    w_easter;
    mfd_pkg::t_date    w_cs;
    mfd_pkg::t_date    w_ce;
    mfd_pkg::t_date    w_gf;
    mfd_pkg::t_date    w_asc;
    mfd_pkg::t_date    w_wh;
    logic              r_strobe;

    // offsets of each feast from march 1
    always_comb begin
        w_off_e  = $signed({2'b0, i_item.off});
        w_easter = mfd_pkg::date_of(w_off_e, i_item.leap);
        w_cs     = mfd_pkg::date_of(w_off_e - 8'sd49, i_item.leap);
        w_ce     = mfd_pkg::date_of(w_off_e - 8'sd47, i_item.leap);
        w_gf     = mfd_pkg::date_of(w_off_e - 8'sd2, i_item.leap);
        w_asc    = mfd_pkg::date_of(w_off_e + 8'sd39, i_item.leap);
        w_wh     = mfd_pkg::date_of(w_off_e + 8'sd49, i_item.leap);
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_item.valid;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        o_easter_mon         <= w_easter.mon[2:0];
        o_easter_dom         <= w_easter.dom;
        o_carnival_start_mon <= w_cs.mon[1:0];
        o_carnival_start_dom <= w_cs.dom;
        o_carnival_end_mon   <= w_ce.mon[1:0];
        o_carnival_end_dom   <= w_ce.dom;
        o_good_friday_mon    <= w_gf.mon[2:0];
        o_good_friday_dom    <= w_gf.dom;
        o_ascension_mon      <= w_asc.mon[2:0];
        o_ascension_dom      <= w_asc.dom;
        o_whitsun_mon        <= w_wh.mon[2:0];
        o_whitsun_dom        <= w_wh.dom;
    end

    assign o_strobe = r_strobe;

endmodule

@@ verif/movable_feast_dates_test.sv @@
// self-checking testbench for the movable feast date block
`timescale 1ns / 1ps

module movable_feast_dates_test;

    localparam int RANDOM_YEARS = 1800;
    // the last items go in back to back, with no gaps
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 200000;

    // one result item at the widths of the result ports
    typedef struct packed {
        logic [2:0] easter_mon;
        logic [4:0] easter_dom;
        logic [1:0] carnival_start_mon;
        logic [4:0] carnival_start_dom;
        logic [1:0] carnival_end_mon;
        logic [4:0] carnival_end_dom;
        logic [2:0] good_friday_mon;
        logic [4:0] good_friday_dom;
        logic [2:0] ascension_mon;
        logic [4:0] ascension_dom;
        logic [2:0] whitsun_mon;
        logic [4:0] whitsun_dom;
    } t_feast_dates;

    // month lengths from march onward
    localparam int MONTH_LEN [0:9] = '{31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_year;
    logic        o_strobe;
    logic [2:0]  o_easter_mon;
    logic [4:0]  o_easter_dom;
    logic [1:0]  o_carnival_start_mon;
    logic [4:0]  o_carnival_start_dom;
    logic [1:0]  o_carnival_end_mon;
    logic [4:0]  o_carnival_end_dom;
    logic [2:0]  o_good_friday_mon;
    logic [4:0]  o_good_friday_dom;
    logic [2:0]  o_ascension_mon;
    logic [4:0]  o_ascension_dom;
    logic [2:0]  o_whitsun_mon;
    logic [4:0]  o_whitsun_dom;

    logic [15:0]  years_to_send [$];
    t_feast_dates dates_due [$];
    int           years_total;
    int           years_taken;
    int           mismatches;
    int           cycle_count;
    int           gap_left;
    logic         last_taken;

    movable_feast_dates i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_year               (i_year),
        .o_strobe             (o_strobe),
        .o_easter_mon         (o_easter_mon),
        .o_easter_dom         (o_easter_dom),
        .o_carnival_start_mon (o_carnival_start_mon),
        .o_carnival_start_dom (o_carnival_start_dom),
        .o_carnival_end_mon   (o_carnival_end_mon),
        .o_carnival_end_dom   (o_carnival_end_dom),
        .o_good_friday_mon    (o_good_friday_mon),
        .o_good_friday_dom    (o_good_friday_dom),
        .o_ascension_mon      (o_ascension_mon),
        .o_ascension_dom      (o_ascension_dom),
        .o_whitsun_mon        (o_whitsun_mon),
        .o_whitsun_dom        (o_whitsun_dom)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // gregorian leap rule
    function automatic bit is_leap(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // easter sunday as days since march 1, anonymous gregorian computus
    function automatic int easter_days(input int yr);
        int gold, cent, yic, cq, cr, fx, gx, epact, yq, yr4, wk, mx, nx;
        gold  = yr % 19;
        cent  = yr / 100;
        yic   = yr % 100;
        cq    = cent / 4;
        cr    = cent % 4;
        fx    = (cent + 8) / 25;
        gx    = (cent - fx + 1) / 3;
        epact = (19 * gold + cent - cq - gx + 15) % 30;
        yq    = yic / 4;
        yr4   = yic % 4;
        wk    = (32 + 2 * cr + 2 * yq - epact - yr4) % 7;
        mx    = (gold + 11 * epact + 22 * wk) / 451;
        nx    = epact + wk - 7 * mx + 114;
        return (nx / 31 == 3) ? (nx % 31) : (31 + nx % 31);
    endfunction

    // days since march 1 to month and day; negative days fall in february
    function automatic void month_day(input int days, input bit leap,
                                      output int mon, output int dom);
        int rest, idx;
        rest = days;
        idx  = 0;
        if (rest < 0) begin
            dom = (leap ? 29 : 28) + rest + 1;
            if (dom < 1) begin
                dom = 1;
            end
            mon = 2;
        end else begin
            while (idx < 10 && rest >= MONTH_LEN[idx]) begin
                rest -= MONTH_LEN[idx];
                idx++;
            end
            mon = 3 + idx;
            dom = rest + 1;
        end
    endfunction

    // all six dates of one year
    function automatic t_feast_dates feast_dates_of(input logic [15:0] yr);
        t_feast_dates r;
        int           eo, mon, dom;
        bit           leap;
        leap = is_leap(int'(yr));
        eo   = easter_days(int'(yr));
        month_day(eo, leap, mon, dom);
        r.easter_mon         = 3'(mon);
        r.easter_dom         = 5'(dom);
        month_day(eo - 49, leap, mon, dom);
        r.carnival_start_mon = 2'(mon);
        r.carnival_start_dom = 5'(dom);
        month_day(eo - 47, leap, mon, dom);
        r.carnival_end_mon   = 2'(mon);
        r.carnival_end_dom   = 5'(dom);
        month_day(eo - 2, leap, mon, dom);
        r.good_friday_mon    = 3'(mon);
        r.good_friday_dom    = 5'(dom);
        month_day(eo + 39, leap, mon, dom);
        r.ascension_mon      = 3'(mon);
        r.ascension_dom      = 5'(dom);
        month_day(eo + 49, leap, mon, dom);
        r.whitsun_mon        = 3'(mon);
        r.whitsun_dom        = 5'(dom);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [4:0] want,
                               input logic [4:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // item list: directed years first, then random ones
    initial begin
        logic [15:0] directed [];
        directed = '{
            16'd0, 16'd1, 16'd65535, 16'd32768, 16'h5555, 16'hAAAA,
            16'd1583, 16'd1818, 16'd2285, 16'd1943, 16'd2038, 16'd1900,
            16'd2000, 16'd2024, 16'd2100, 16'd1954, 16'd1981, 16'd2008,
            16'd2400, 16'd65532, 16'd2049, 16'd2076
        };
        foreach (directed[j]) begin
            years_to_send.push_back(directed[j]);
        end
        // mostly the whole field, a share in the usual calendar range
        for (int j = 0; j < RANDOM_YEARS; j++) begin
            if ($urandom_range(0, 2) == 0) begin
                years_to_send.push_back(16'($urandom_range(1583, 2500)));
            end else begin
                years_to_send.push_back(16'($urandom_range(0, 65535)));
            end
        end
        years_total = years_to_send.size();
    end

    // reset, then wait for every result and report the verdict
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_year      = '0;
        years_taken = 0;
        mismatches  = 0;
        gap_left    = 0;
        last_taken  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (years_taken < years_total || dates_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (mfd_pkg::LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0 && dates_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // driver: present the next year at the falling edge, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || last_taken)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (years_to_send.size() != 0) begin
                if (start && years_to_send.size() > CALM_ITEMS
                        && $urandom_range(0, 3) == 0) begin
                    gap_left <= $urandom_range(0, 7);
                    start    <= 1'b0;
                end else begin
                    start  <= 1'b1;
                    i_year <= years_to_send.pop_front();
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, then record each accepted year
    always @(posedge i_clk) begin
        t_feast_dates want;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (dates_due.size() == 0) begin
                    $error("result with no item outstanding");
                    mismatches++;
                end else begin
                    want = dates_due.pop_front();
                    check_field("easter_mon", want.easter_mon, o_easter_mon);
                    check_field("easter_dom", want.easter_dom, o_easter_dom);
                    check_field("carnival_start_mon", want.carnival_start_mon,
                                o_carnival_start_mon);
                    check_field("carnival_start_dom", want.carnival_start_dom,
                                o_carnival_start_dom);
                    check_field("carnival_end_mon", want.carnival_end_mon,
                                o_carnival_end_mon);
                    check_field("carnival_end_dom", want.carnival_end_dom,
                                o_carnival_end_dom);
                    check_field("good_friday_mon", want.good_friday_mon, o_good_friday_mon);
                    check_field("good_friday_dom", want.good_friday_dom, o_good_friday_dom);
                    check_field("ascension_mon", want.ascension_mon, o_ascension_mon);
                    check_field("ascension_dom", want.ascension_dom, o_ascension_dom);
                    check_field("whitsun_mon", want.whitsun_mon, o_whitsun_mon);
                    check_field("whitsun_dom", want.whitsun_dom, o_whitsun_dom);
                end
            end
            if (start && busy === 1'b0) begin
                dates_due.push_back(feast_dates_of(i_year));
                years_taken++;
                last_taken <= 1'b1;
            end else begin
                last_taken <= 1'b0;
            end
        end
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
